/* rtl/core/sha1_pkg.sv */
// SHA-1 shared package: initial vector, round constants, round phase type,
// the round function and the control bundle between sequencer and datapath.
// No dependencies.
package sha1_pkg;

    typedef logic [4:0][31:0] t_words;

    // Initial chaining value, word A at index 0
    localparam t_words SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    localparam logic [31:0] SHA1_K0 = 32'h5A827999;
    localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

    // First padding byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // One of the four 20-round groups
    typedef enum logic [1:0] {
        PH_CHOOSE = 2'd0,
        PH_PARITY_LO = 2'd1,
        PH_MAJORITY = 2'd2,
        PH_PARITY_HI = 2'd3
    } t_phase;

    // Sequencer to datapath control
    typedef struct packed {
        logic       push_byte;   // shift a byte into the word packer
        logic       push_word;   // this byte completes a word: push it into the schedule
        logic [7:0] byte_val;
        logic       load_work;   // copy chain words into the working variables
        logic       round_en;    // run one round
        t_phase     phase;
        logic       fold;        // add working variables into the chain
        logic       init_chain;  // return chain to the initial vector
    } t_core_ctl;

    function automatic logic [31:0] sha1_f(input t_phase ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        unique case (ph)
            PH_CHOOSE:    res = (b & c) | (~b & d);
            PH_MAJORITY:  res = (b & c) | (b & d) | (c & d);
            PH_PARITY_LO,
            PH_PARITY_HI: res = b ^ c ^ d;
            default:      res = b ^ c ^ d;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] sha1_k(input t_phase ph);
        logic [31:0] res;
        unique case (ph)
            PH_CHOOSE:    res = SHA1_K0;
            PH_PARITY_LO: res = SHA1_K1;
            PH_MAJORITY:  res = SHA1_K2;
            PH_PARITY_HI: res = SHA1_K3;
            default:      res = SHA1_K3;
        endcase
        return res;
    endfunction

endpackage

/* rtl/core/sha1_if.sv */
// Valid/ready channel interfaces of the SHA-1 block: byte items in,
// digest items out. No dependencies.
interface sha1_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
    logic        overflow_error;

    modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                    digest_word4, overflow_error, input ready);
    modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                    digest_word4, overflow_error, output ready);
endinterface

/* rtl/core/sha1_byte_stream_hash.sv */
// SHA-1 over a byte stream: top level with the block sequencer and the
// digest output register. Depends on sha1_pkg, sha1_if and sha1_core.
//
//  channel   dir  payload                                         accepted when
//  i_item    in   data_byte[7:0], byte_valid, end_of_message      valid & ready
//  o_result  out  digest_word0..4[31:0], overflow_error           valid & ready
//
// A byte item is taken while idle. The item that fills a 64-byte block
// starts 80 rounds on the single round unit followed by a fold.
// An end-of-message item pads one byte per cycle through the same path up
// to the block end, then runs the rounds and the fold; a second padding block
// follows when the length spills into it, and then the result is loaded.
// ready is low from the item that starts a block or a finish until that
// work is done; a finished digest waits in the output register until taken.
// Reset (synchronous, active low) restores the initial vector and clears all counts.
module sha1_byte_stream_hash
    import sha1_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sha1_byte_if.sink            i_item,
    sha1_digest_if.source        o_result
);

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_P1   = 7'd20;
    localparam logic [6:0] ROUND_P2   = 7'd40;
    localparam logic [6:0] ROUND_P3   = 7'd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        AFTER_IDLE,
        AFTER_PAD,
        AFTER_EMIT
    } t_after;

    t_state      r_state, n_state;
    t_after      r_after, n_after;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_cnt, n_cnt;      // message length in bytes
    logic        r_ovf, n_ovf;
    logic        r_first, n_first;  // next pad byte is the marker
    logic        r_wrap, n_wrap;    // length goes into a further block
    logic [6:0]  r_round, n_round;
    logic        r_out_valid, n_out_valid;
    t_words      r_digest;
    logic        r_err;

    t_core_ctl   w_ctl;
    t_words      w_chain;
    logic        w_wr;
    logic        w_load_out;
    logic [61:0] w_cnt_sum;
    logic [63:0] w_bit_len;
    logic [7:0]  w_len_byte;
    logic [7:0]  w_pad_byte;

    sha1_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_chain (w_chain)
    );

    // Byte counter increment with carry into the overflow flag
    assign w_cnt_sum = {1'b0, r_cnt} + 62'd1;
    assign w_wr      = i_item.byte_valid && !r_ovf;

    // Padding byte: marker, zeros, then the big-endian bit length
    assign w_bit_len  = {r_cnt, 3'b000};
    assign w_len_byte = w_bit_len[{~r_fill[2:0], 3'b000} +: 8];
    always_comb begin
        priority if (r_first) begin
            w_pad_byte = PAD_MARK;
        end else if (r_fill >= LEN_POS && !r_wrap) begin
            w_pad_byte = w_len_byte;
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_first     = r_first;
        n_wrap      = r_wrap;
        n_round     = r_round;
        n_out_valid = r_out_valid && !o_result.ready;
        w_load_out  = 1'b0;
        w_ctl       = '0;

        priority if (r_round < ROUND_P1) begin
            w_ctl.phase = PH_CHOOSE;
        end else if (r_round < ROUND_P2) begin
            w_ctl.phase = PH_PARITY_LO;
        end else if (r_round < ROUND_P3) begin
            w_ctl.phase = PH_MAJORITY;
        end else begin
            w_ctl.phase = PH_PARITY_HI;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    if (w_wr) begin
                        w_ctl.push_byte = 1'b1;
                        w_ctl.push_word = (r_fill[1:0] == 2'b11);
                        w_ctl.byte_val  = i_item.data_byte;
                        n_fill          = r_fill + 6'd1;
                        n_cnt           = w_cnt_sum[60:0];
                        n_ovf           = w_cnt_sum[61];
                    end
                    if (i_item.end_of_message) begin
                        n_first = 1'b1;
                    end
                    priority if (i_item.end_of_message && (r_ovf || (w_wr && w_cnt_sum[61])))
                    begin
                        n_state = ST_EMIT;
                    end else if (w_wr && r_fill == FILL_LAST) begin
                        w_ctl.load_work = 1'b1;
                        n_round         = '0;
                        n_state         = ST_ROUND;
                        n_after         = i_item.end_of_message ? AFTER_PAD : AFTER_IDLE;
                    end else if (i_item.end_of_message) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ROUND: begin
                w_ctl.round_en = 1'b1;
                n_round        = r_round + 7'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                w_ctl.fold = 1'b1;
                unique case (r_after)
                    AFTER_IDLE: n_state = ST_IDLE;
                    AFTER_PAD:  n_state = ST_PAD;
                    AFTER_EMIT: n_state = ST_EMIT;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_PAD: begin
                w_ctl.push_byte = 1'b1;
                w_ctl.push_word = (r_fill[1:0] == 2'b11);
                w_ctl.byte_val  = w_pad_byte;
                n_fill          = r_fill + 6'd1;
                n_first         = 1'b0;
                if (r_first && r_fill >= LEN_POS) begin
                    n_wrap = 1'b1;
                end
                if (r_fill == FILL_LAST) begin
                    w_ctl.load_work = 1'b1;
                    n_round         = '0;
                    n_state         = ST_ROUND;
                    if (r_wrap || r_first) begin
                        n_after = AFTER_PAD;
                        n_wrap  = 1'b0;
                    end else begin
                        n_after = AFTER_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_result.ready) begin
                    w_load_out       = 1'b1;
                    n_out_valid      = 1'b1;
                    w_ctl.init_chain = 1'b1;
                    n_fill           = '0;
                    n_cnt            = '0;
                    n_ovf            = 1'b0;
                    n_first          = 1'b0;
                    n_wrap           = 1'b0;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_after     <= AFTER_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_first     <= 1'b0;
            r_wrap      <= 1'b0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_first     <= n_first;
            r_wrap      <= n_wrap;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
            if (w_load_out) begin
                r_digest <= r_ovf ? '0 : w_chain;
                r_err    <= r_ovf;
            end
        end
    end

    assign i_item.ready            = (r_state == ST_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.digest_word0   = r_digest[0];
    assign o_result.digest_word1   = r_digest[1];
    assign o_result.digest_word2   = r_digest[2];
    assign o_result.digest_word3   = r_digest[3];
    assign o_result.digest_word4   = r_digest[4];
    assign o_result.overflow_error = r_err;

endmodule

/* rtl/core/sha1_core.sv */
// SHA-1 datapath: byte-to-word packer, 16-word message schedule shift line,
// one shared round unit and the chaining words. Depends on sha1_pkg.
module sha1_core
    import sha1_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    output t_words    o_chain
);

    logic [23:0]       r_pack;
    logic [15:0][31:0] r_w;
    t_words            r_work;
    t_words            r_chain;

    logic [31:0] w_new_word;
    logic [31:0] w_sched;
    logic [31:0] w_f;
    logic [31:0] w_t;

    assign w_new_word = {r_pack, i_ctl.byte_val};

    // Next schedule word: W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
    always_comb begin
        w_sched = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_sched = {w_sched[30:0], w_sched[31]};
    end

    // Round unit: T = rotl5(A) + f(B,C,D) + E + W[t] + K
    assign w_f = sha1_f(i_ctl.phase, r_work[1], r_work[2], r_work[3]);
    assign w_t = {r_work[0][26:0], r_work[0][31:27]} + w_f + r_work[4] + r_w[0]
               + sha1_k(i_ctl.phase);

    // Packer, schedule and working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_byte) begin
            r_pack <= {r_pack[15:0], i_ctl.byte_val};
        end
        if (i_ctl.push_byte && i_ctl.push_word) begin
            r_w <= {w_new_word, r_w[15:1]};
        end else if (i_ctl.round_en) begin
            r_w <= {w_sched, r_w[15:1]};
        end
        if (i_ctl.load_work) begin
            r_work <= r_chain;
        end else if (i_ctl.round_en) begin
            r_work[0] <= w_t;
            r_work[1] <= r_work[0];
            r_work[2] <= {r_work[1][1:0], r_work[1][31:2]};
            r_work[3] <= r_work[2];
            r_work[4] <= r_work[3];
        end
    end

    // Chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init_chain) begin
            r_chain <= SHA1_IV;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= r_chain[i] + r_work[i];
            end
        end
    end

    assign o_chain = r_chain;

endmodule
